FILE: sv/swkr_pkg.sv
// ----------------------------------------------------------------------------
// swkr_pkg: shared types for the keyed-removal stack
// Operation and status codes, controller states and the cell control word.
// ----------------------------------------------------------------------------
package swkr_pkg;

  localparam int CODE_W = 32;
  localparam int POS_W  = 5;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  typedef struct packed {
    logic load;   // capture match flags, place token at top entry
    logic push;   // write code into the cell at the fill level
    logic step;   // move token one cell toward the bottom
    logic shift;  // close the gap over the matched entry
  } cell_ctl_t;

endpackage

FILE: sv/swkr_cell.sv
// ----------------------------------------------------------------------------
// swkr_cell: one stack slot
// Holds one code, a registered match flag, and the scan token with a
// visited mark; takes code and token from the cell above.
// ----------------------------------------------------------------------------
module swkr_cell
  import swkr_pkg::*;
#(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic [CW-1:0]     cnt,
  input  logic [CODE_W-1:0] code,
  input  logic [CODE_W-1:0] above_entry,
  input  logic              above_token,
  output logic [CODE_W-1:0] entry,
  output logic              token,
  output logic              hit
);

  logic [CODE_W-1:0] entry_r;
  logic              match_r;
  logic              token_r;
  logic              seen_r;

  always_ff @(posedge clk) begin
    if (ctl.push && (cnt == CW'(IDX))) begin
      entry_r <= code;
    end else if (ctl.shift && (seen_r || token_r)) begin
      entry_r <= above_entry;
    end
    if (ctl.load) begin
      match_r <= (entry_r == code);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      token_r <= 1'b0;
      seen_r  <= 1'b0;
    end else if (ctl.load) begin
      token_r <= (cnt == CW'(IDX + 1));
      seen_r  <= 1'b0;
    end else if (ctl.step) begin
      token_r <= above_token;
      seen_r  <= seen_r | token_r;
    end
  end

  assign entry = entry_r;
  assign token = token_r;
  assign hit   = token_r & match_r;

endmodule

FILE: sv/stack_with_keyed_removal.sv
// ----------------------------------------------------------------------------
// stack_with_keyed_removal: bounded code stack with find and keyed removal
// Push, remove topmost match, find topmost match, over a chain of cells.
//
//   channel   ports                                   transfer when
//   input     start, busy, in_op, in_code             start && !busy
//   result    out_valid, out_status, out_position,    out_valid (one cycle)
//             out_count
//
// Push, op 3 and any op on an empty stack: result in the cycle after start.
// Find/remove: a token walks down from the top entry, one cell per cycle;
// result when the token reaches a match or the bottom entry, busy high meanwhile.
// Removal slides the cells above the match down in the closing cycle.
// Reset empties the stack; the receiver cannot stall results.
// ----------------------------------------------------------------------------
module stack_with_keyed_removal
  import swkr_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_op,
  input  logic [CODE_W-1:0] in_code,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [POS_W-1:0]  out_position,
  output logic [POS_W-1:0]  out_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic              rm_r, rm_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [POS_W-1:0]  out_position_r, out_position_nxt;
  logic [POS_W-1:0]  out_count_r, out_count_nxt;
  cell_ctl_t         ctl;
  logic              accept;
  logic              any_hit;

  logic [CODE_W-1:0] entry_vec [DEPTH];
  logic [DEPTH-1:0]  tok_vec;
  logic [DEPTH-1:0]  hit_vec;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [CODE_W-1:0] above_entry;
    logic              above_token;
    if (i == DEPTH - 1) begin : g_top
      assign above_entry = entry_vec[i];
      assign above_token = 1'b0;
    end else begin : g_mid
      assign above_entry = entry_vec[i+1];
      assign above_token = tok_vec[i+1];
    end
    swkr_cell #(
      .IDX(i),
      .CW (CW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .cnt        (cnt_r),
      .code       (in_code),
      .above_entry(above_entry),
      .above_token(above_token),
      .entry      (entry_vec[i]),
      .token      (tok_vec[i]),
      .hit        (hit_vec[i])
    );
  end

  assign accept  = start && (state_r == S_IDLE);
  assign any_hit = |hit_vec;

  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    idx_nxt          = idx_r;
    rm_nxt           = rm_r;
    out_valid_nxt    = 1'b0;
    out_status_nxt   = out_status_r;
    out_position_nxt = out_position_r;
    out_count_nxt    = out_count_r;
    ctl              = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_position_nxt = '0;
          out_status_nxt   = STAT_OK;
          case (in_op)
            OP_PUSH: begin
              out_valid_nxt = 1'b1;
              if (cnt_r == CW'(DEPTH)) begin
                out_status_nxt = STAT_FULL;
              end else begin
                ctl.push         = 1'b1;
                cnt_nxt          = cnt_r + 1'b1;
                out_position_nxt = POS_W'(cnt_nxt);
              end
            end
            OP_REMOVE, OP_FIND: begin
              if (cnt_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_EMPTY;
              end else begin
                ctl.load  = 1'b1;
                idx_nxt   = IW'(cnt_r - 1'b1);
                rm_nxt    = (in_op == OP_REMOVE);
                state_nxt = S_SCAN;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
          out_count_nxt = POS_W'(cnt_nxt);
        end
      end
      S_SCAN: begin
        if (any_hit) begin
          out_valid_nxt    = 1'b1;
          out_status_nxt   = STAT_OK;
          out_position_nxt = POS_W'(CW'(idx_r) + 1'b1);
          if (rm_r) begin
            ctl.shift = 1'b1;
            cnt_nxt   = cnt_r - 1'b1;
          end
          out_count_nxt = POS_W'(cnt_nxt);
          state_nxt     = S_IDLE;
        end else if (idx_r == '0) begin
          out_valid_nxt    = 1'b1;
          out_status_nxt   = STAT_NOTFOUND;
          out_position_nxt = '0;
          out_count_nxt    = POS_W'(cnt_r);
          state_nxt        = S_IDLE;
        end else begin
          ctl.step = 1'b1;
          idx_nxt  = idx_r - 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r          <= idx_nxt;
    rm_r           <= rm_nxt;
    out_status_r   <= out_status_nxt;
    out_position_r <= out_position_nxt;
    out_count_r    <= out_count_nxt;
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_position = out_position_r;
  assign out_count    = out_count_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe while scan still running");

  a_token_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec))
    else $error("more than one scan token in the chain");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("fill count beyond depth");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (cnt_r != '0))
    else $error("scan on empty stack");

  a_token_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> tok_vec[idx_r])
    else $error("token position out of step with scan index");

  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != STAT_OK)) |-> (out_position_r == '0))
    else $error("nonzero position on failed operation");

endmodule
